// ===== hw/rtl/hnc_pkg.sv =====
// Shared types and constants for the heightmap normal block
package hnc_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned HGT_W    = 16;
  localparam int unsigned NRM_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned DIFF_W   = HGT_W + 1;
  localparam int unsigned SQR_W    = 2 * DIFF_W - 1;
  localparam int unsigned SUM_W    = SQR_W + 1;
  localparam int unsigned RAD_W    = SUM_W + 16;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  localparam int unsigned QUO_W    = 17;
  localparam int unsigned DEN_W    = ROOT_W + 1;
  localparam int unsigned NUM_W    = DEN_W + QUO_W;
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam logic [SUM_W-1:0]  DY_SQ  = SUM_W'(262144);
  localparam logic [HGT_W-1:0]  DY_MAG = HGT_W'(512);

  localparam logic [DIM_W-1:0]      MAP_W_RST = DIM_W'(256);
  localparam logic [DIM_W-1:0]      MAP_D_RST = DIM_W'(256);
  localparam logic signed [HGT_W-1:0] EDGE_RST = '0;

  localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32767);
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(32768);

  // front stages, sqrt, prep, divide, saturate
  localparam int unsigned PIPE_LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_DEPTH   = 2'd1,
    REG_EDGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
  } grad_t;

endpackage

// ===== hw/rtl/hnc_if.sv =====
// Valid/ready channel interfaces for cells in and normals out
interface hnc_in_if;
  logic                            valid;
  logic                            ready;
  logic [hnc_pkg::COORD_W-1:0]     cell_x;
  logic [hnc_pkg::COORD_W-1:0]     cell_z;
  logic signed [hnc_pkg::HGT_W-1:0] height_center;
  logic signed [hnc_pkg::HGT_W-1:0] height_right;
  logic signed [hnc_pkg::HGT_W-1:0] height_left;
  logic signed [hnc_pkg::HGT_W-1:0] height_down;
  logic signed [hnc_pkg::HGT_W-1:0] height_up;

  modport source (output valid, cell_x, cell_z, height_center, height_right,
                  height_left, height_down, height_up, input ready);
  modport sink (input valid, cell_x, cell_z, height_center, height_right,
                height_left, height_down, height_up, output ready);
endinterface

interface hnc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [hnc_pkg::NRM_W-1:0] normal_x;
  logic signed [hnc_pkg::NRM_W-1:0] normal_y;
  logic signed [hnc_pkg::NRM_W-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== hw/rtl/hnc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband
module hnc_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hnc_pkg::RAD_W-1:0]   rad_in,
  input  hnc_pkg::grad_t              side_in,
  output logic [hnc_pkg::ROOT_W-1:0]  root_out,
  output hnc_pkg::grad_t              side_out
);
  import hnc_pkg::*;

  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  logic [RAD_W-1:0]  rad_r  [SQRT_STEPS];
  grad_t             side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    grad_t             side_p;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_in;
      assign side_p = side_in;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      trial  = REM_W'({root_p, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_p << 2;
        side_r[k] <= side_p;
      end
    end
  end

  assign root_out = root_r[SQRT_STEPS-1];
  assign side_out = side_r[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/hnc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, sign carried along
module hnc_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hnc_pkg::NUM_W-1:0]  num_in,
  input  logic [hnc_pkg::DEN_W-1:0]  den_in,
  input  logic                       neg_in,
  output logic [hnc_pkg::QUO_W-1:0]  quo_out,
  output logic                       neg_out
);
  import hnc_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_STEPS];
  logic [DEN_W-1:0] den_r [DIV_STEPS];
  logic [QUO_W-1:0] quo_r [DIV_STEPS];
  logic             neg_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int unsigned SH = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p;
    logic             neg_p;
    logic [NUM_W-1:0] dsh;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_p = num_in;
      assign den_p = den_in;
      assign quo_p = '0;
      assign neg_p = neg_in;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign quo_p = quo_r[k-1];
      assign neg_p = neg_r[k-1];
    end

    assign dsh  = NUM_W'(den_p) << SH;
    assign take = (rem_p >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? (rem_p - dsh) : rem_p;
        den_r[k] <= den_p;
        quo_r[k] <= {quo_p[QUO_W-2:0], take};
        neg_r[k] <= neg_p;
      end
    end
  end

  assign quo_out = quo_r[DIV_STEPS-1];
  assign neg_out = neg_r[DIV_STEPS-1];

endmodule

// ===== hw/rtl/heightmap_normal_calc_core.sv =====
// Heightmap surface normal core: neighbour select, length, per-component divide
//
// Usage:
//   in_chan carries one cell per transfer: coordinates and the five heights
//   (Q8.8). Neighbours outside map_width x map_depth take edge_height.
//   out_chan carries one unit normal (Q1.15, saturated) per cell, in order.
//   cfg_we/cfg_index/cfg_wdata write map_width (0), map_depth (1) and
//   edge_height (2); write only while no cell is in flight.
// Timing:
//   A cell can be taken every cycle unless the skid register holds a result;
//   throughput is then one normal per cycle. Cells pass four front stages,
//   a 25-stage square root (one root bit per stage), one prep stage,
//   a 17-stage divider (one quotient bit per stage) and a saturate stage.
// Reset and stall:
//   rst_n (synchronous, active low) empties the pipeline and restores the
//   registers to 256, 256 and 0. When out_chan.ready is low the head result
//   drops into a one-entry skid register and the pipeline freezes on the
//   following cycle; in_chan.ready is low only while that skid holds a result.
module heightmap_normal_calc_core (
  input  logic                            clk,
  input  logic                            rst_n,
  hnc_in_if.sink                          in_chan,
  hnc_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [hnc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnc_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import hnc_pkg::*;

  logic [DIM_W-1:0]        map_w_r, map_d_r;
  logic signed [HGT_W-1:0] edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= MAP_W_RST;
      map_d_r <= MAP_D_RST;
      edge_r  <= EDGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:   map_w_r <= cfg_wdata[DIM_W-1:0];
        REG_MAP_DEPTH:   map_d_r <= cfg_wdata[DIM_W-1:0];
        REG_EDGE_HEIGHT: edge_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;
  logic vld_r [PIPE_LAT];

  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int i = 1; i < PIPE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  logic [DIM_W-1:0] x_e, z_e, xp1, xm1, zp1, zm1;
  logic out_r, out_l, out_d, out_u;

  always_comb begin
    x_e = DIM_W'(in_chan.cell_x);
    z_e = DIM_W'(in_chan.cell_z);
    xp1 = x_e + DIM_W'(1);
    xm1 = x_e - DIM_W'(1);
    zp1 = z_e + DIM_W'(1);
    zm1 = z_e - DIM_W'(1);
    out_r = (xp1 >= map_w_r) || (z_e >= map_d_r);
    out_l = (x_e == '0) || (xm1 >= map_w_r) || (z_e >= map_d_r);
    out_d = (x_e >= map_w_r) || (zp1 >= map_d_r);
    out_u = (z_e == '0) || (x_e >= map_w_r) || (zm1 >= map_d_r);
  end

  logic signed [HGT_W-1:0]  hr_r, hl_r, hd_r, hu_r;
  grad_t                    grad_r;
  logic [SQR_W-1:0]         dx2_r, dz2_r;
  grad_t                    grad2_r;
  logic [RAD_W-1:0]         rad_r;
  grad_t                    grad3_r;
  logic signed [SQR_W:0]    dx2_full, dz2_full;

  assign dx2_full = grad_r.dx * grad_r.dx;
  assign dz2_full = grad_r.dz * grad_r.dz;

  always_ff @(posedge clk) begin
    if (en) begin
      hr_r      <= out_r ? edge_r : in_chan.height_right;
      hl_r      <= out_l ? edge_r : in_chan.height_left;
      hd_r      <= out_d ? edge_r : in_chan.height_down;
      hu_r      <= out_u ? edge_r : in_chan.height_up;
      grad_r.dx <= DIFF_W'(hr_r) - DIFF_W'(hl_r);
      grad_r.dz <= DIFF_W'(hd_r) - DIFF_W'(hu_r);
      dx2_r     <= dx2_full[SQR_W-1:0];
      dz2_r     <= dz2_full[SQR_W-1:0];
      grad2_r   <= grad_r;
      rad_r     <= {SUM_W'(dx2_r) + SUM_W'(dz2_r) + DY_SQ, 16'b0};
      grad3_r   <= grad2_r;
    end
  end

  logic [ROOT_W-1:0] root;
  grad_t             grad4;

  hnc_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (rad_r),
    .side_in  (grad3_r),
    .root_out (root),
    .side_out (grad4)
  );

  logic [HGT_W-1:0] mag_x, mag_z;
  logic [NUM_W-1:0] num_x_r, num_y_r, num_z_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_x_r, neg_z_r;

  assign mag_x = HGT_W'(grad4.dx[DIFF_W-1] ? -grad4.dx : grad4.dx);
  assign mag_z = HGT_W'(grad4.dz[DIFF_W-1] ? -grad4.dz : grad4.dz);

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r <= (NUM_W'(mag_x) << 24) + NUM_W'(root);
      num_y_r <= (NUM_W'(DY_MAG) << 24) + NUM_W'(root);
      num_z_r <= (NUM_W'(mag_z) << 24) + NUM_W'(root);
      den_r   <= {root, 1'b0};
      neg_x_r <= grad4.dx[DIFF_W-1];
      neg_z_r <= grad4.dz[DIFF_W-1];
    end
  end

  logic [QUO_W-1:0] q_x, q_y, q_z;
  logic             n_x, n_y, n_z;

  hnc_div u_div_x (.clk(clk), .en(en), .num_in(num_x_r), .den_in(den_r),
                   .neg_in(neg_x_r), .quo_out(q_x), .neg_out(n_x));
  hnc_div u_div_y (.clk(clk), .en(en), .num_in(num_y_r), .den_in(den_r),
                   .neg_in(1'b1), .quo_out(q_y), .neg_out(n_y));
  hnc_div u_div_z (.clk(clk), .en(en), .num_in(num_z_r), .den_in(den_r),
                   .neg_in(neg_z_r), .quo_out(q_z), .neg_out(n_z));

  function automatic logic [NRM_W-1:0] sat_comp(logic [QUO_W-1:0] q, logic neg);
    logic [QUO_W-1:0] m;
    if (neg) begin
      m = (q > NEG_LIM) ? NEG_LIM : q;
      m = -m;
    end else begin
      m = (q > POS_LIM) ? POS_LIM : q;
    end
    return m[NRM_W-1:0];
  endfunction

  logic [NRM_W-1:0] nx_r, ny_r, nz_r;
  logic [NRM_W-1:0] skx_r, sky_r, skz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= sat_comp(q_x, n_x);
      ny_r <= sat_comp(q_y, n_y);
      nz_r <= sat_comp(q_z, n_z);
    end
  end

  logic head_v;
  assign head_v = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_chan.ready) skid_v_r <= 1'b0;
    end else if (head_v && !out_chan.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skx_r <= nx_r;
      sky_r <= ny_r;
      skz_r <= nz_r;
    end
  end

  assign out_chan.valid    = skid_v_r || head_v;
  assign out_chan.normal_x = skid_v_r ? skx_r : nx_r;
  assign out_chan.normal_y = skid_v_r ? sky_r : ny_r;
  assign out_chan.normal_z = skid_v_r ? skz_r : nz_r;

`ifndef SYNTHESIS
  a_skid_from_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(head_v && !out_chan.ready))
    else $error("skid filled without a stalled head result");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_chan.ready |=> skid_v_r && $stable(skx_r))
    else $error("skid result lost under stall");

  a_ny_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.normal_y[NRM_W-1] || out_chan.normal_y == '0))
    else $error("normal_y positive");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(nx_r) && $stable(ny_r) && $stable(nz_r))
    else $error("pipeline head moved while skid full");
`endif

endmodule
